// ===== hw/rtl/mpmc_pkg.sv =====
// Package for the multi-pattern match counter: item kinds, controller states
// and fixed field widths. No dependencies.
package mpmc_pkg;

   localparam int COUNT_W = 12;
   localparam int TOTAL_W = 16;
   localparam logic [COUNT_W-1:0] END_MAX = 12'hFFF;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      KIND_PAT_LETTER  = 3'd0,
      KIND_PAT_END     = 3'd1,
      KIND_BUILD       = 3'd2,
      KIND_TEXT_LETTER = 3'd3,
      KIND_TEXT_END    = 3'd4
   } mpmc_kind_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PL,
      S_PE,
      S_B0,
      S_BQ,
      S_BU,
      S_BF,
      S_BG,
      S_BL,
      S_BFILL,
      S_T,
      S_TW,
      S_EMIT
   } mpmc_state_type;

endpackage

// ===== hw/rtl/mpmc_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing.
interface mpmc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [4:0] letter;
   modport source (output valid, output kind, output letter, input ready);
   modport sink (input valid, input kind, input letter, output ready);
endinterface

interface mpmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] match_count;
   logic        node_overflow;
   modport source (output valid, output match_count, output node_overflow, input ready);
   modport sink (input valid, input match_count, input node_overflow, output ready);
endinterface

// ===== hw/rtl/mpmc_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module mpmc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/multi_pattern_match_counter_unit.sv =====
// Multi-pattern match counter (Aho-Corasick automaton over a small alphabet).
// Depends on mpmc_pkg, mpmc_if (channel interfaces) and mpmc_ram.
//
// Usage: words arrive on req_chan (kind, letter). Pattern letters grow a trie
// held in the goto memory, pattern ends count a pattern at the current node,
// a build word computes failure links breadth-first and fills missing goto
// entries, text letters step the automaton and a text end returns one word
// on rsp_chan carrying the saturating match count and the overflow flag.
// A text letter that lands on a node other than the root walks the failure
// chain from that node, adding the count of each unconsumed node and marking
// it consumed, and stops at the root or at a consumed node (each node is
// consumed once overall). The build first queues the children of the root,
// then works through the queued nodes in turn. One word is worked on at a
// time. Reset starts a clearing pass that writes zero to every goto, failure
// and count entry, one address a cycle; no word is accepted during it.
// Results sit in an output register, so a stalled receiver only holds the
// block back when a second text end arrives while the first result has not
// been taken yet.
module multi_pattern_match_counter_unit #(
   parameter int NODES    = 4096,
   parameter int ALPHABET = 26
) (
   input  logic        clock,
   input  logic        reset,
   mpmc_req_if.sink    req_chan,
   mpmc_rsp_if.source  rsp_chan
);

   localparam int NW = $clog2(NODES);
   localparam int LW = $clog2(ALPHABET);
   localparam int GD = NODES * ALPHABET;
   localparam int GW = $clog2(GD);
   localparam int CW = mpmc_pkg::COUNT_W;
   localparam int TW = mpmc_pkg::TOTAL_W;
   localparam logic [GW-1:0] ALPHA_G = GW'(ALPHABET);
   localparam logic [GW-1:0] CLR_LAST = GW'(GD - 1);
   localparam logic [GW-1:0] CLR_NODES = GW'(NODES);
   localparam logic [NW-1:0] NODE_LAST = NW'(NODES - 1);
   localparam logic [NW:0]   QUEUE_CAP = (NW + 1)'(NODES);
   localparam logic [LW-1:0] LETTER_LAST = LW'(ALPHABET - 1);

   // Goto memory address of (node, letter).
   function automatic logic [GW-1:0] gaddr(input logic [NW-1:0] node,
                                           input logic [LW-1:0] x);
      gaddr = GW'(node) * ALPHA_G + GW'(x);
   endfunction

   mpmc_pkg::mpmc_state_type state_ff, state_in;
   logic [GW-1:0] clr_ff, clr_in;
   logic [NW-1:0] node_total_ff, node_total_in;
   logic [NW-1:0] insert_ff, insert_in;
   logic [NW-1:0] text_ff, text_in;
   logic [NW-1:0] q_ff, q_in;
   logic [NW-1:0] u_ff, u_in;
   logic [NW-1:0] f_ff, f_in;
   logic [NW-1:0] v_ff, v_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] x_ff, x_in;
   logic [NW:0]   head_ff, head_in;
   logic [NW:0]   tail_ff, tail_in;
   logic [TW-1:0] total_ff, total_in;
   logic          ovf_ff, ovf_in;
   logic          built_ff, built_in;
   logic          drop_ff, drop_in;
   logic          out_valid_ff, out_valid_in;
   logic [TW-1:0] out_count_ff, out_count_in;
   logic          out_ovf_ff, out_ovf_in;

   // Memory ports.
   logic          g_we;
   logic [GW-1:0] g_waddr, g_raddr;
   logic [NW-1:0] g_wdata, g_rdata;
   logic          fl_we;
   logic [NW-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
   logic          ec_we;
   logic [NW-1:0] ec_waddr, ec_raddr;
   logic [CW:0]   ec_wdata, ec_rdata;
   logic          qu_we;
   logic [NW-1:0] qu_waddr, qu_raddr, qu_wdata, qu_rdata;

   logic          letter_ok;
   logic [LW-1:0] lx;
   logic [CW-1:0] ec_cnt;
   logic [TW:0]   sum;
   logic          emit_load;

   mpmc_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
      .clock(clock), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
      .raddr(g_raddr), .rdata(g_rdata)
   );
   mpmc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
      .clock(clock), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
      .raddr(fl_raddr), .rdata(fl_rdata)
   );
   mpmc_ram #(.WIDTH(CW + 1), .DEPTH(NODES)) u_endc (
      .clock(clock), .we(ec_we), .waddr(ec_waddr), .wdata(ec_wdata),
      .raddr(ec_raddr), .rdata(ec_rdata)
   );
   mpmc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
      .clock(clock), .we(qu_we), .waddr(qu_waddr), .wdata(qu_wdata),
      .raddr(qu_raddr), .rdata(qu_rdata)
   );

   // Input words are taken only while the controller waits for work.
   assign req_chan.ready = (state_ff == mpmc_pkg::S_IDLE);
   assign letter_ok = (9'(req_chan.letter) < 9'(ALPHABET));
   assign lx = LW'(req_chan.letter);
   // The count field carries the consumed mark in its top bit.
   assign ec_cnt = ec_rdata[CW-1:0];
   assign sum = {1'b0, total_ff} + (TW + 1)'(ec_cnt);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      node_total_in = node_total_ff;
      insert_in = insert_ff;
      text_in = text_ff;
      q_in = q_ff;
      u_in = u_ff;
      f_in = f_ff;
      v_in = v_ff;
      i_in = i_ff;
      x_in = x_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      total_in = total_ff;
      ovf_in = ovf_ff;
      built_in = built_ff;
      drop_in = drop_ff;
      emit_load = 1'b0;
      g_we = 1'b0;
      g_waddr = gaddr(u_ff, i_ff);
      g_wdata = g_rdata;
      g_raddr = gaddr(u_ff, i_ff);
      fl_we = 1'b0;
      fl_waddr = v_ff;
      fl_wdata = g_rdata;
      fl_raddr = q_ff;
      ec_we = 1'b0;
      ec_waddr = q_ff;
      ec_wdata = {1'b1, ec_cnt};
      ec_raddr = q_ff;
      qu_we = 1'b0;
      qu_waddr = tail_ff[NW-1:0];
      qu_wdata = g_rdata;
      qu_raddr = head_ff[NW-1:0];

      case (state_ff)
         mpmc_pkg::S_CLEAR: begin
            g_we = 1'b1;
            g_waddr = clr_ff;
            g_wdata = '0;
            if (clr_ff < CLR_NODES) begin
               fl_we = 1'b1;
               fl_waddr = clr_ff[NW-1:0];
               fl_wdata = '0;
               ec_we = 1'b1;
               ec_waddr = clr_ff[NW-1:0];
               ec_wdata = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = mpmc_pkg::S_IDLE;
            end
         end

         mpmc_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.kind)
                  mpmc_pkg::KIND_PAT_LETTER: begin
                     if (letter_ok && !built_ff && !drop_ff) begin
                        g_raddr = gaddr(insert_ff, lx);
                        x_in = lx;
                        state_in = mpmc_pkg::S_PL;
                     end
                  end
                  mpmc_pkg::KIND_PAT_END: begin
                     if (!built_ff) begin
                        if (drop_ff) begin
                           drop_in = 1'b0;
                           insert_in = '0;
                        end else begin
                           ec_raddr = insert_ff;
                           state_in = mpmc_pkg::S_PE;
                        end
                     end
                  end
                  mpmc_pkg::KIND_BUILD: begin
                     if (!built_ff) begin
                        built_in = 1'b1;
                        head_in = '0;
                        tail_in = '0;
                        i_in = '0;
                        g_raddr = gaddr('0, '0);
                        state_in = mpmc_pkg::S_B0;
                     end
                  end
                  mpmc_pkg::KIND_TEXT_LETTER: begin
                     if (letter_ok) begin
                        g_raddr = gaddr(text_ff, lx);
                        state_in = mpmc_pkg::S_T;
                     end
                  end
                  mpmc_pkg::KIND_TEXT_END: begin
                     state_in = mpmc_pkg::S_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Pattern letter: follow or allocate a child; set overflow when full.
         mpmc_pkg::S_PL: begin
            state_in = mpmc_pkg::S_IDLE;
            if (g_rdata != '0) begin
               insert_in = g_rdata;
            end else if (node_total_ff == NODE_LAST) begin
               ovf_in = 1'b1;
               drop_in = 1'b1;
            end else begin
               node_total_in = node_total_ff + 1'b1;
               insert_in = node_total_ff + 1'b1;
               g_we = 1'b1;
               g_waddr = gaddr(insert_ff, x_ff);
               g_wdata = node_total_ff + 1'b1;
            end
         end

         mpmc_pkg::S_PE: begin
            if (ec_cnt != mpmc_pkg::END_MAX) begin
               ec_we = 1'b1;
               ec_waddr = insert_ff;
               ec_wdata = {ec_rdata[CW], ec_cnt + 1'b1};
            end
            insert_in = '0;
            drop_in = 1'b0;
            state_in = mpmc_pkg::S_IDLE;
         end

         // Root row: queue every child of the root.
         mpmc_pkg::S_B0: begin
            if (g_rdata != '0 && tail_ff < QUEUE_CAP) begin
               qu_we = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            if (i_ff == LETTER_LAST) begin
               state_in = mpmc_pkg::S_BQ;
            end else begin
               i_in = i_ff + 1'b1;
               g_raddr = gaddr('0, i_ff + 1'b1);
            end
         end

         mpmc_pkg::S_BQ: begin
            if (head_ff < tail_ff) begin
               head_in = head_ff + 1'b1;
               state_in = mpmc_pkg::S_BU;
            end else begin
               state_in = mpmc_pkg::S_IDLE;
            end
         end

         mpmc_pkg::S_BU: begin
            u_in = qu_rdata;
            fl_raddr = qu_rdata;
            state_in = mpmc_pkg::S_BF;
         end

         mpmc_pkg::S_BF: begin
            f_in = fl_rdata;
            i_in = '0;
            g_raddr = gaddr(u_ff, '0);
            state_in = mpmc_pkg::S_BG;
         end

         // Child of u is known; fetch the failure node's entry for the letter.
         mpmc_pkg::S_BG: begin
            v_in = g_rdata;
            g_raddr = gaddr(f_ff, i_ff);
            state_in = (g_rdata != '0) ? mpmc_pkg::S_BL : mpmc_pkg::S_BFILL;
         end

         mpmc_pkg::S_BL, mpmc_pkg::S_BFILL: begin
            if (state_ff == mpmc_pkg::S_BL) begin
               fl_we = 1'b1;
               if (tail_ff < QUEUE_CAP) begin
                  qu_we = 1'b1;
                  qu_wdata = v_ff;
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               g_we = 1'b1;
            end
            if (i_ff == LETTER_LAST) begin
               state_in = mpmc_pkg::S_BQ;
            end else begin
               i_in = i_ff + 1'b1;
               g_raddr = gaddr(u_ff, i_ff + 1'b1);
               state_in = mpmc_pkg::S_BG;
            end
         end

         mpmc_pkg::S_T: begin
            text_in = g_rdata;
            q_in = g_rdata;
            if (g_rdata != '0) begin
               ec_raddr = g_rdata;
               fl_raddr = g_rdata;
               state_in = mpmc_pkg::S_TW;
            end else begin
               state_in = mpmc_pkg::S_IDLE;
            end
         end

         // Failure chain walk; the chain only gets shallower, so the node
         // written here is never the one read in the same cycle.
         mpmc_pkg::S_TW: begin
            if (ec_rdata[CW]) begin
               state_in = mpmc_pkg::S_IDLE;
            end else begin
               total_in = sum[TW] ? mpmc_pkg::TOTAL_MAX : sum[TW-1:0];
               ec_we = 1'b1;
               q_in = fl_rdata;
               ec_raddr = fl_rdata;
               fl_raddr = fl_rdata;
               if (fl_rdata == '0) begin
                  state_in = mpmc_pkg::S_IDLE;
               end
            end
         end

         mpmc_pkg::S_EMIT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               emit_load = 1'b1;
               state_in = mpmc_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mpmc_pkg::S_IDLE;
         end
      endcase
   end

   assign out_valid_in = (out_valid_ff && !rsp_chan.ready) || emit_load;
   assign out_count_in = emit_load ? total_ff : out_count_ff;
   assign out_ovf_in = emit_load ? ovf_ff : out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpmc_pkg::S_CLEAR;
         clr_ff <= '0;
         node_total_ff <= '0;
         insert_ff <= '0;
         text_ff <= '0;
         total_ff <= '0;
         ovf_ff <= 1'b0;
         built_ff <= 1'b0;
         drop_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         node_total_ff <= node_total_in;
         insert_ff <= insert_in;
         text_ff <= text_in;
         total_ff <= total_in;
         ovf_ff <= ovf_in;
         built_ff <= built_in;
         drop_ff <= drop_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         out_valid_ff <= out_valid_in;
      end
      q_ff <= q_in;
      u_ff <= u_in;
      f_ff <= f_in;
      v_ff <= v_in;
      i_ff <= i_in;
      x_ff <= x_in;
      out_count_ff <= out_count_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.match_count = out_count_ff;
   assign rsp_chan.node_overflow = out_ovf_ff;

   // No word may be taken while the memories are being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == mpmc_pkg::S_CLEAR |-> !req_chan.ready)
      else $error("word accepted during clearing pass");

   // The node allocator never runs past the last node.
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      node_total_ff <= NODE_LAST)
      else $error("node count beyond capacity");

   // The breadth-first queue head never passes its tail.
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   // The match total only grows between resets.
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("match total decreased");

   // A new result only appears after a text end was processed.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == mpmc_pkg::S_EMIT)
      else $error("result raised outside emit state");

endmodule
